// File: rtl/core/ltk_pkg.sv
// Shared types, constants and fixed-point scaling functions for the light tracker.
// Depends on nothing; the filter, servo, result queue and top files import it.
`default_nettype none

package ltk_pkg;

  // Moving-average window.
  localparam int WINDOW_LEN = 5;
  localparam int POS_W      = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int LEVEL_W    = 7;
  localparam int ADC_W      = 12;
  localparam int CHANNELS   = 4;
  localparam int SUM_W      = $clog2(100 * WINDOW_LEN + 1);

  // Result queue and outstanding transaction count.
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int OCC_W      = $clog2(FIFO_DEPTH + 1);

  // Reset values of the servo angles and of the configuration registers.
  localparam logic [8:0] PAN_RESET      = 9'd135;
  localparam logic [7:0] TILT_RESET     = 8'd90;
  localparam logic [6:0] DEADBAND_RESET = 7'd3;
  localparam logic [8:0] PAN_MIN_RESET  = 9'd20;
  localparam logic [8:0] PAN_MAX_RESET  = 9'd265;
  localparam logic [7:0] TILT_MIN_RESET = 8'd30;
  localparam logic [7:0] TILT_MAX_RESET = 8'd150;

  // Reciprocal constants. Each quotient is floor(x * M >> K), exact over the input range.
  localparam int LVL_K  = 25;
  localparam int LVL_MW = 20;
  localparam logic [63:0] LVL_M64 = (64'd100 * (64'd1 << LVL_K) + 64'd4094) / 64'd4095;
  localparam logic [LVL_MW-1:0] LVL_M = LVL_M64[LVL_MW-1:0];

  localparam int AVG_K  = 16;
  localparam int AVG_MW = 17;
  localparam logic [63:0] AVG_M64 =
    ((64'd1 << AVG_K) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);
  localparam logic [AVG_MW-1:0] AVG_M = AVG_M64[AVG_MW-1:0];

  localparam int CMP_K   = 20;
  localparam int PAN_MW  = 23;
  localparam int TILT_MW = 24;
  localparam logic [63:0] PAN_M64  = (64'd2000 * (64'd1 << CMP_K) + 64'd269) / 64'd270;
  localparam logic [63:0] TILT_M64 = (64'd2000 * (64'd1 << CMP_K) + 64'd179) / 64'd180;
  localparam logic [PAN_MW-1:0]  PAN_M  = PAN_M64[PAN_MW-1:0];
  localparam logic [TILT_MW-1:0] TILT_M = TILT_M64[TILT_MW-1:0];

  localparam logic [12:0] CMP_OFFSET = 13'd500;
  localparam logic [12:0] CMP_LIMIT  = 13'd4095;

  typedef logic [CHANNELS-1:0][LEVEL_W-1:0] level_vec_t;
  typedef logic [CHANNELS-1:0][ADC_W-1:0]   adc_vec_t;

  typedef struct packed {
    logic [6:0] deadband;
    logic [8:0] pan_min;
    logic [8:0] pan_max;
    logic [7:0] tilt_min;
    logic [7:0] tilt_max;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic tick;
  } filt_stat_t;

  typedef struct packed {
    logic [8:0]        pan_angle;
    logic [7:0]        tilt_angle;
    logic [11:0]       pan_compare;
    logic [11:0]       tilt_compare;
    logic signed [7:0] vertical_diff;
    logic signed [7:0] horizontal_diff;
  } result_t;

  // 100 - floor(adc * 100 / 4095)
  function automatic logic [LEVEL_W-1:0] adc_to_level(input logic [ADC_W-1:0] adc);
    logic [ADC_W+LVL_MW-1:0] prod;
    prod = (ADC_W + LVL_MW)'(adc) * (ADC_W + LVL_MW)'(LVL_M);
    return 7'd100 - prod[LVL_K +: LEVEL_W];
  endfunction

  // floor(sum / WINDOW_LEN)
  function automatic logic [LEVEL_W-1:0] avg_level(input logic [SUM_W-1:0] sum);
    logic [SUM_W+AVG_MW-1:0] prod;
    prod = (SUM_W + AVG_MW)'(sum) * (SUM_W + AVG_MW)'(AVG_M);
    return prod[AVG_K +: LEVEL_W];
  endfunction

  // floor(angle * 2000 / 270) + 500, saturated to 4095
  function automatic logic [11:0] pan_to_compare(input logic [8:0] angle);
    logic [9+PAN_MW-1:0] prod;
    logic [12:0]         total;
    prod  = (9 + PAN_MW)'(angle) * (9 + PAN_MW)'(PAN_M);
    total = {1'b0, prod[CMP_K +: 12]} + CMP_OFFSET;
    return (total > CMP_LIMIT) ? CMP_LIMIT[11:0] : total[11:0];
  endfunction

  // floor(angle * 2000 / 180) + 500, saturated to 4095
  function automatic logic [11:0] tilt_to_compare(input logic [7:0] angle);
    logic [8+TILT_MW-1:0] prod;
    logic [12:0]          total;
    prod  = (8 + TILT_MW)'(angle) * (8 + TILT_MW)'(TILT_M);
    total = {1'b0, prod[CMP_K +: 12]} + CMP_OFFSET;
    return (total > CMP_LIMIT) ? CMP_LIMIT[11:0] : total[11:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/ltk_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module ltk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/ltk_filter.sv
// Moving-average filter: window RAM read-modify-write, running sums, smoothed levels.
// Depends on ltk_pkg and ltk_ram.
`default_nettype none

module ltk_filter (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic                mode,
  input  ltk_pkg::adc_vec_t   adc,
  output ltk_pkg::filt_stat_t stat,
  output ltk_pkg::level_vec_t smoothed
);
  import ltk_pkg::*;

  logic [POS_W-1:0]      pos;
  logic [WINDOW_LEN-1:0] row_valid;

  logic                  s1_valid;
  logic                  s1_sample;
  logic [POS_W-1:0]      s1_pos;
  level_vec_t            s1_levels;
  logic                  s1_fwd;
  level_vec_t            s1_fwd_row;
  logic                  s1_rv;

  logic [CHANNELS-1:0][SUM_W-1:0] sums;
  logic [CHANNELS-1:0][SUM_W-1:0] sums_next;
  level_vec_t            smoothed_next;
  level_vec_t            levels_in;
  level_vec_t            ram_rdata;
  level_vec_t            old_row;
  logic                  rd_en;
  logic                  hit;
  logic [SUM_W:0]        wide;

  assign rd_en = take && !mode;
  // The previous sample writes its row this cycle; the RAM would return stale data.
  assign hit   = s1_valid && s1_sample && (s1_pos == pos);

  always_comb begin
    for (int ch = 0; ch < CHANNELS; ch++) begin
      levels_in[ch] = adc_to_level(adc[ch]);
    end
  end

  ltk_ram #(
    .WIDTH ($bits(level_vec_t)),
    .DEPTH (WINDOW_LEN),
    .AW    (POS_W)
  ) u_window (
    .clk   (clk),
    .we    (s1_valid && s1_sample),
    .waddr (s1_pos),
    .wdata (s1_levels),
    .re    (rd_en),
    .raddr (pos),
    .rdata (ram_rdata)
  );

  always_comb begin
    if (s1_fwd) begin
      old_row = s1_fwd_row;
    end else if (s1_rv) begin
      old_row = ram_rdata;
    end else begin
      old_row = '0;
    end
    wide = '0;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      wide = {1'b0, sums[ch]} + (SUM_W + 1)'(s1_levels[ch]) - (SUM_W + 1)'(old_row[ch]);
      sums_next[ch]     = wide[SUM_W-1:0];
      smoothed_next[ch] = avg_level(sums_next[ch]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      row_valid <= '0;
      s1_valid  <= 1'b0;
      sums      <= '0;
      smoothed  <= '0;
      stat      <= '0;
    end else begin
      s1_valid <= take;
      if (rd_en) begin
        pos <= (pos == POS_W'(WINDOW_LEN - 1)) ? '0 : pos + 1'b1;
      end
      if (s1_valid && s1_sample) begin
        row_valid[s1_pos] <= 1'b1;
        sums              <= sums_next;
        smoothed          <= smoothed_next;
      end
      stat.valid <= s1_valid;
      stat.tick  <= s1_valid && !s1_sample;
    end
    if (take) begin
      s1_sample  <= !mode;
      s1_pos     <= pos;
      s1_levels  <= levels_in;
      s1_fwd     <= hit;
      s1_fwd_row <= s1_levels;
      s1_rv      <= row_valid[pos] || hit;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/ltk_servo.sv
// Pair means, error terms, deadband stepping of the angles and PWM compare scaling.
// Depends on ltk_pkg.
`default_nettype none

module ltk_servo (
  input  logic                clk,
  input  logic                rst,
  input  ltk_pkg::filt_stat_t stat,
  input  ltk_pkg::level_vec_t smoothed,
  input  ltk_pkg::cfg_t       cfg,
  output logic                push,
  output ltk_pkg::result_t    res
);
  import ltk_pkg::*;

  logic [8:0]        pan;
  logic [7:0]        tilt;
  logic [8:0]        pan_next;
  logic [7:0]        tilt_next;
  logic [7:0]        up;
  logic [7:0]        down;
  logic [7:0]        left;
  logic [7:0]        right;
  logic signed [7:0] vdiff;
  logic signed [7:0] hdiff;
  logic signed [8:0] db;

  logic              s3_valid;
  logic [8:0]        s3_pan;
  logic [7:0]        s3_tilt;
  logic signed [7:0] s3_vdiff;
  logic signed [7:0] s3_hdiff;

  always_comb begin
    up    = (8'(smoothed[0]) + 8'(smoothed[1])) >> 1;
    down  = (8'(smoothed[2]) + 8'(smoothed[3])) >> 1;
    left  = (8'(smoothed[0]) + 8'(smoothed[2])) >> 1;
    right = (8'(smoothed[1]) + 8'(smoothed[3])) >> 1;
    vdiff = signed'(up - down);
    hdiff = signed'(left - right);
    db    = signed'({2'b00, cfg.deadband});

    pan_next  = pan;
    tilt_next = tilt;
    if (stat.tick) begin
      // An error inside the deadband leaves the angle where it is.
      priority if (9'(hdiff) >= db) begin
        if (pan > cfg.pan_min) pan_next = pan - 1'b1;
      end else if (9'(hdiff) <= -db) begin
        if (pan < cfg.pan_max) pan_next = pan + 1'b1;
      end else begin
        pan_next = pan;
      end
      priority if (9'(vdiff) >= db) begin
        if (tilt > cfg.tilt_min) tilt_next = tilt - 1'b1;
      end else if (9'(vdiff) <= -db) begin
        if (tilt < cfg.tilt_max) tilt_next = tilt + 1'b1;
      end else begin
        tilt_next = tilt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pan      <= PAN_RESET;
      tilt     <= TILT_RESET;
      s3_valid <= 1'b0;
    end else begin
      pan      <= pan_next;
      tilt     <= tilt_next;
      s3_valid <= stat.valid;
    end
    if (stat.valid) begin
      s3_pan   <= pan_next;
      s3_tilt  <= tilt_next;
      s3_vdiff <= vdiff;
      s3_hdiff <= hdiff;
    end
  end

  assign push                = s3_valid;
  assign res.pan_angle       = s3_pan;
  assign res.tilt_angle      = s3_tilt;
  assign res.pan_compare     = pan_to_compare(s3_pan);
  assign res.tilt_compare    = tilt_to_compare(s3_tilt);
  assign res.vertical_diff   = s3_vdiff;
  assign res.horizontal_diff = s3_hdiff;

endmodule

`default_nettype wire

// File: rtl/core/ltk_result_fifo.sv
// Result queue between the servo stage and the output channel.
// Depends on ltk_pkg.
`default_nettype none

module ltk_result_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ltk_pkg::result_t push_data,
  input  logic             pop,
  output logic             not_empty,
  output ltk_pkg::result_t head_data
);
  import ltk_pkg::*;

  result_t               mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] head;
  logic [FIFO_PTR_W-1:0] tail;
  logic [OCC_W-1:0]      count;

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) tail <= tail + 1'b1;
      if (pop)  head <= head + 1'b1;
      count <= count + OCC_W'(push) - OCC_W'(pop);
    end
    if (push) begin
      mem[tail] <= push_data;
    end
  end

  assign not_empty = (count != '0);
  assign head_data = mem[head];

endmodule

`default_nettype wire

// File: rtl/core/four_quadrant_light_tracker_top.sv
// Four-quadrant light tracker. An accepted input transaction passes the window read stage,
// the sum update and the angle step, then compare scaling, into the result queue.
// Throughput: one transaction per cycle; in_ready drops only while eight transactions are
// outstanding, which is the depth of the result queue.
// Reset (rst, synchronous): window valid bits, running sums and smoothed levels cleared,
// angles to 135 and 90, registers to their defaults; no clearing pass is needed.
`default_nettype none

module four_quadrant_light_tracker_top (
  input  logic        clk,
  input  logic        rst,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [11:0] sensor_a,
  input  logic [11:0] sensor_b,
  input  logic [11:0] sensor_c,
  input  logic [11:0] sensor_d,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [8:0]  pan_angle,
  output logic [7:0]  tilt_angle,
  output logic [11:0] pan_compare,
  output logic [11:0] tilt_compare,
  output logic signed [7:0] vertical_diff,
  output logic signed [7:0] horizontal_diff,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ltk_pkg::*;

  // Register map: index i sits at byte address 4*i.
  typedef enum logic [2:0] {
    REG_DEADBAND = 3'd0,
    REG_PAN_MIN  = 3'd1,
    REG_PAN_MAX  = 3'd2,
    REG_TILT_MIN = 3'd3,
    REG_TILT_MAX = 3'd4
  } reg_idx_t;

  cfg_t             cfg;
  reg_idx_t         idx;
  logic             wr_en;
  logic             take;
  logic             pop;
  logic [OCC_W-1:0] occ;
  filt_stat_t       stat;
  level_vec_t       smoothed;
  logic             push;
  result_t          res;
  result_t          head;
  adc_vec_t         adc;

  // The configuration port never stalls; a write lands on the access phase.
  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.deadband <= DEADBAND_RESET;
      cfg.pan_min  <= PAN_MIN_RESET;
      cfg.pan_max  <= PAN_MAX_RESET;
      cfg.tilt_min <= TILT_MIN_RESET;
      cfg.tilt_max <= TILT_MAX_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_DEADBAND: cfg.deadband <= pwdata[6:0];
        REG_PAN_MIN:  cfg.pan_min  <= pwdata[8:0];
        REG_PAN_MAX:  cfg.pan_max  <= pwdata[8:0];
        REG_TILT_MIN: cfg.tilt_min <= pwdata[7:0];
        REG_TILT_MAX: cfg.tilt_max <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_DEADBAND: prdata = 32'(cfg.deadband);
      REG_PAN_MIN:  prdata = 32'(cfg.pan_min);
      REG_PAN_MAX:  prdata = 32'(cfg.pan_max);
      REG_TILT_MIN: prdata = 32'(cfg.tilt_min);
      REG_TILT_MAX: prdata = 32'(cfg.tilt_max);
      default:      prdata = '0;
    endcase
  end

  // Every accepted transaction produces exactly one result. Counting those accepted but
  // not yet delivered, and capping the count at the queue depth, guarantees the queue
  // always has room for whatever is still in the pipeline, so the pipeline never stalls.
  assign in_ready = (occ < OCC_W'(FIFO_DEPTH));
  assign take     = in_valid && in_ready;
  assign pop      = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      occ <= occ + OCC_W'(take) - OCC_W'(pop);
    end
  end

  assign adc[0] = sensor_a;
  assign adc[1] = sensor_b;
  assign adc[2] = sensor_c;
  assign adc[3] = sensor_d;

  // Sample transactions write their levels into the window RAM and update the running
  // sums; tick transactions pass through untouched so that ordering is kept.
  ltk_filter u_filter (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .mode     (mode),
    .adc      (adc),
    .stat     (stat),
    .smoothed (smoothed)
  );

  // Error terms come from the smoothed levels as they stand after each transaction;
  // ticks step the angles, and the compare values follow one stage later.
  ltk_servo u_servo (
    .clk      (clk),
    .rst      (rst),
    .stat     (stat),
    .smoothed (smoothed),
    .cfg      (cfg),
    .push     (push),
    .res      (res)
  );

  ltk_result_fifo u_results (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (res),
    .pop       (pop),
    .not_empty (out_valid),
    .head_data (head)
  );

  assign pan_angle       = head.pan_angle;
  assign tilt_angle      = head.tilt_angle;
  assign pan_compare     = head.pan_compare;
  assign tilt_compare    = head.tilt_compare;
  assign vertical_diff   = head.vertical_diff;
  assign horizontal_diff = head.horizontal_diff;

endmodule

`default_nettype wire
